FILE: rtl/bra_pkg.sv
// bra_pkg: shared types and constants for the bitmap run allocator
// no dependencies; imported by bra_run_finder and bitmap_run_allocator
`default_nettype none

package bra_pkg;

  // chunk map of one page: a set bit is a free 64-byte chunk
  localparam int MAP_W  = 64;
  localparam int SLOT_W = 6;
  localparam int BIT_W  = 6;
  localparam int RUN_W  = 7;
  localparam int BYTE_W = 13;
  localparam int STAT_W = 3;

  // largest rounded request that still fits a page with its header chunk
  localparam logic [BYTE_W-1:0] MAX_BYTES = 13'd4032;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_LARGE   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOSLOT  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OVERLAP = 3'd4;
  localparam logic [STAT_W-1:0] STAT_DOUBLE  = 3'd5;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [MAP_W-1:0] map_t;

  // one slot read launched into the run finder
  typedef struct packed {
    logic              vld;
    logic              last;
    logic              open;
    logic [SLOT_W-1:0] slot;
  } issue_t;

  // outcome of the run search on one slot
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [BIT_W-1:0]  lo;
  } find_res_t;

endpackage

`default_nettype wire

FILE: rtl/bra_ram.sv
// bra_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire                                         clk,
  input  wire                                         wr_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]                            wr_data,
  input  wire                                         rd_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bra_run_finder.sv
// bra_run_finder: pipelined search for the lowest run of set bits in a slot map
// depends on bra_pkg; fed by the map ram read port of the top level
`default_nettype none

module bra_run_finder
  import bra_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    flush,
  input  issue_t                 iss,
  input  wire  [2:0]             run_k,
  input  wire  [4:0]             run_rem,
  input  map_t                   rd_data,
  output find_res_t              res,
  output map_t                   res_map
);

  issue_t    p0_r, p0_nxt;
  issue_t    sa_r, sa_nxt;
  find_res_t sb_r, sb_nxt;
  map_t      sa_starts_r, sa_starts_nxt;
  map_t      sa_map_r;
  map_t      sb_map_r;

  map_t y1, y2, y3, y4, y5, y6, ysel;
  logic [BIT_W-1:0] lo_found;
  logic             any_found;

  // doubling ladder: bit j of yk marks 2^k set bits from j upwards
  always_comb begin
    y1 = rd_data & (rd_data >> 1);
    y2 = y1 & (y1 >> 2);
    y3 = y2 & (y2 >> 4);
    y4 = y3 & (y3 >> 8);
    y5 = y4 & (y4 >> 16);
    y6 = y5 & (y5 >> 32);
    case (run_k)
      3'd1:    ysel = y1;
      3'd2:    ysel = y2;
      3'd3:    ysel = y3;
      3'd4:    ysel = y4;
      3'd5:    ysel = y5;
      3'd6:    ysel = y6;
      default: ysel = rd_data;
    endcase
    sa_starts_nxt = (ysel & (ysel >> run_rem)) & {MAP_W{p0_r.open}};
  end

  // lowest start bit of a fitting run gives the lowest end bit too
  always_comb begin
    lo_found  = '0;
    any_found = 1'b0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (sa_starts_r[i]) begin
        lo_found  = BIT_W'(i);
        any_found = 1'b1;
      end
    end
  end

  // pipeline control
  always_comb begin
    p0_nxt      = iss;
    sa_nxt      = p0_r;
    sb_nxt.vld  = sa_r.vld;
    sb_nxt.hit  = any_found;
    sb_nxt.last = sa_r.last;
    sb_nxt.slot = sa_r.slot;
    sb_nxt.lo   = lo_found;
    if (flush) begin
      p0_nxt.vld = 1'b0;
      sa_nxt.vld = 1'b0;
      sb_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r.vld <= 1'b0;
      sa_r.vld <= 1'b0;
      sb_r.vld <= 1'b0;
    end else begin
      p0_r.vld <= p0_nxt.vld;
      sa_r.vld <= sa_nxt.vld;
      sb_r.vld <= sb_nxt.vld;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    p0_r.last   <= p0_nxt.last;
    p0_r.open   <= p0_nxt.open;
    p0_r.slot   <= p0_nxt.slot;
    sa_r.last   <= sa_nxt.last;
    sa_r.open   <= sa_nxt.open;
    sa_r.slot   <= sa_nxt.slot;
    sa_starts_r <= sa_starts_nxt;
    sa_map_r    <= rd_data;
    sb_r.hit    <= sb_nxt.hit;
    sb_r.last   <= sb_nxt.last;
    sb_r.slot   <= sb_nxt.slot;
    sb_r.lo     <= sb_nxt.lo;
    sb_map_r    <= sa_map_r;
  end

  assign res     = sb_r;
  assign res_map = sb_map_r;

endmodule

`default_nettype wire

FILE: rtl/bitmap_run_allocator.sv
// bitmap_run_allocator: top level, command sequencer, slot valid bits and map ram
// depends on bra_pkg, bra_ram and bra_run_finder
`default_nettype none

// A command is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with out_valid, and the receiver cannot stall
// it. Size errors and malformed frees answer in the cycle after the command.
// A free reads its slot map, checks it in S_FREE and answers from the result
// register. An allocation reads one slot map per cycle from the map ram into
// the p0, sa and sb stages of the run search over min(SLOTS,64) slots; a hit
// ends the scan and a miss answers with the last slot's result. The map
// ram is not cleared: a slot's map is written when the slot is opened.
module bitmap_run_allocator
  import bra_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire                     in_cmd,
  input  wire  [BYTE_W-1:0]       in_request_bytes,
  input  wire  [SLOT_W-1:0]       in_free_slot,
  input  wire  [BIT_W-1:0]        in_free_end_bit,
  input  wire  [RUN_W-1:0]        in_free_run,
  output logic                    out_valid,
  output logic [STAT_W-1:0]       out_status,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [BIT_W-1:0]        out_end_bit,
  output logic [RUN_W-1:0]        out_run_chunks,
  output logic                    out_new_page
);

  localparam int USED = (SLOTS < 64) ? SLOTS : 64;
  localparam int AW   = (USED > 1) ? $clog2(USED) : 1;
  localparam logic [RUN_W-1:0] USED_N = RUN_W'(USED);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;

  function automatic map_t ones(input logic [RUN_W-1:0] n);
    map_t v;
    if (n >= RUN_W'(MAP_W)) begin
      v = '1;
    end else begin
      v = (map_t'(1) << n) - map_t'(1);
    end
    return v;
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [RUN_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              fe_found_r, fe_found_nxt;
  logic [SLOT_W-1:0] fe_r, fe_nxt;
  logic [USED-1:0]   slot_valid_r, slot_valid_nxt;

  logic [RUN_W-1:0]  run_r, run_nxt;
  map_t              mask_r, mask_nxt;
  logic [2:0]        run_k_r, run_k_nxt;
  logic [4:0]        run_rem_r, run_rem_nxt;
  logic [SLOT_W-1:0] fslot_r, fslot_nxt;

  logic              o_valid_r, o_valid_nxt;
  logic [STAT_W-1:0] o_status_r, o_status_nxt;
  logic [SLOT_W-1:0] o_slot_r, o_slot_nxt;
  logic [BIT_W-1:0]  o_end_bit_r, o_end_bit_nxt;
  logic [RUN_W-1:0]  o_run_r, o_run_nxt;
  logic              o_new_page_r, o_new_page_nxt;

  logic              accept;
  logic [BYTE_W:0]   bytes_up;
  logic [RUN_W-1:0]  alloc_run;
  logic [RUN_W-1:0]  run_top;
  logic [RUN_W-1:0]  end_plus;
  logic [RUN_W-1:0]  free_lo;
  logic              free_bad;

  issue_t            iss;
  find_res_t         res;
  map_t              res_map;
  map_t              rd_data;
  logic              flush;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  map_t              wr_data;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // command decode: chunk count with header, and free run geometry
  always_comb begin
    bytes_up  = {1'b0, in_request_bytes} + (BYTE_W+1)'(63);
    alloc_run = {1'b0, bytes_up[11:6]} + RUN_W'(1);
    run_top   = '0;
    for (int i = 0; i < RUN_W; i++) begin
      if (alloc_run[i]) begin
        run_top = RUN_W'(i);
      end
    end
    end_plus = {1'b0, in_free_end_bit} + RUN_W'(1);
    free_lo  = end_plus - in_free_run;
    free_bad = ({1'b0, in_free_slot} >= USED_N) || (in_free_run > end_plus);
  end

  // map ram, one entry per usable slot
  bra_ram #(
    .WIDTH (MAP_W),
    .DEPTH (USED)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // run search pipeline
  bra_run_finder u_finder (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush   (flush),
    .iss     (iss),
    .run_k   (run_k_r),
    .run_rem (run_rem_r),
    .rd_data (rd_data),
    .res     (res),
    .res_map (res_map)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    fe_found_nxt   = fe_found_r;
    fe_nxt         = fe_r;
    slot_valid_nxt = slot_valid_r;
    run_nxt        = run_r;
    mask_nxt       = mask_r;
    run_k_nxt      = run_k_r;
    run_rem_nxt    = run_rem_r;
    fslot_nxt      = fslot_r;

    o_valid_nxt    = 1'b0;
    o_status_nxt   = o_status_r;
    o_slot_nxt     = o_slot_r;
    o_end_bit_nxt  = o_end_bit_r;
    o_run_nxt      = o_run_r;
    o_new_page_nxt = o_new_page_r;

    iss.vld  = 1'b0;
    iss.last = (scan_idx_r == (USED_N - RUN_W'(1)));
    iss.open = slot_valid_r[scan_idx_r[AW-1:0]];
    iss.slot = scan_idx_r[SLOT_W-1:0];
    flush    = 1'b0;

    rd_en   = 1'b0;
    rd_addr = scan_idx_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = res.slot[AW-1:0];
    wr_data = res_map & ~(mask_r << res.lo);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          o_status_nxt   = STAT_OK;
          o_slot_nxt     = '0;
          o_end_bit_nxt  = '0;
          o_run_nxt      = '0;
          o_new_page_nxt = 1'b0;
          if (in_cmd == CMD_ALLOC) begin
            run_nxt      = alloc_run;
            mask_nxt     = ones(alloc_run);
            run_k_nxt    = run_top[2:0];
            run_rem_nxt  = 5'(alloc_run & ~(RUN_W'(1) << run_top));
            scan_idx_nxt = '0;
            fe_found_nxt = 1'b0;
            if (in_request_bytes == '0) begin
              o_valid_nxt  = 1'b1;
              o_status_nxt = STAT_ZERO;
            end else if (in_request_bytes > MAX_BYTES) begin
              o_valid_nxt  = 1'b1;
              o_status_nxt = STAT_LARGE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            fslot_nxt = in_free_slot;
            mask_nxt  = ones(in_free_run) << free_lo[BIT_W-1:0];
            if (in_free_run == '0) begin
              o_valid_nxt  = 1'b1;
              o_status_nxt = STAT_DOUBLE;
            end else if (free_bad) begin
              o_valid_nxt  = 1'b1;
              o_status_nxt = STAT_OVERLAP;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = in_free_slot[AW-1:0];
              state_nxt = S_FREE;
            end
          end
        end
      end

      S_SCAN: begin
        // launch one slot read per cycle, noting the first unopened slot
        if (scan_idx_r < USED_N) begin
          iss.vld      = 1'b1;
          rd_en        = 1'b1;
          scan_idx_nxt = scan_idx_r + RUN_W'(1);
          if (!slot_valid_r[scan_idx_r[AW-1:0]] && !fe_found_r) begin
            fe_found_nxt = 1'b1;
            fe_nxt       = scan_idx_r[SLOT_W-1:0];
          end
        end
        // search outcome for the oldest slot in flight
        if (res.vld && res.hit) begin
          wr_en         = 1'b1;
          o_valid_nxt   = 1'b1;
          o_slot_nxt    = res.slot;
          o_end_bit_nxt = BIT_W'({1'b0, res.lo} + run_r - RUN_W'(1));
          o_run_nxt     = run_r;
          flush         = 1'b1;
          state_nxt     = S_IDLE;
        end else if (res.vld && res.last) begin
          o_valid_nxt = 1'b1;
          flush       = 1'b1;
          state_nxt   = S_IDLE;
          if (fe_found_r) begin
            // open a fresh page with the run taken from its bottom
            wr_en          = 1'b1;
            wr_addr        = fe_r[AW-1:0];
            wr_data        = ~mask_r;
            slot_valid_nxt[fe_r[AW-1:0]] = 1'b1;
            o_slot_nxt     = fe_r;
            o_end_bit_nxt  = BIT_W'(run_r - RUN_W'(1));
            o_run_nxt      = run_r;
            o_new_page_nxt = 1'b1;
          end else begin
            o_status_nxt = STAT_NOSLOT;
          end
        end
      end

      S_FREE: begin
        // overlap check against the map read back, then merge the run
        o_valid_nxt = 1'b1;
        state_nxt   = S_IDLE;
        if ((rd_data & mask_r) != '0) begin
          o_status_nxt = STAT_OVERLAP;
        end else begin
          wr_en   = 1'b1;
          wr_addr = fslot_r[AW-1:0];
          wr_data = rd_data | mask_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      o_valid_r    <= 1'b0;
      scan_idx_r   <= '0;
      fe_found_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      o_valid_r    <= o_valid_nxt;
      scan_idx_r   <= scan_idx_nxt;
      fe_found_r   <= fe_found_nxt;
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    fe_r         <= fe_nxt;
    run_r        <= run_nxt;
    mask_r       <= mask_nxt;
    run_k_r      <= run_k_nxt;
    run_rem_r    <= run_rem_nxt;
    fslot_r      <= fslot_nxt;
    o_status_r   <= o_status_nxt;
    o_slot_r     <= o_slot_nxt;
    o_end_bit_r  <= o_end_bit_nxt;
    o_run_r      <= o_run_nxt;
    o_new_page_r <= o_new_page_nxt;
  end

  // result transfer
  assign out_valid      = o_valid_r;
  assign out_status     = o_status_r;
  assign out_slot       = o_slot_r;
  assign out_end_bit    = o_end_bit_r;
  assign out_run_chunks = o_run_r;
  assign out_new_page   = o_new_page_r;

endmodule

`default_nettype wire
